FILE: sv/fcr_pkg.sv
// Shared constants and result type for the framed command receiver.
`timescale 1ns / 1ps

package fcr_pkg;

    localparam int MAX_PAYLOAD_LIMIT = 8;
    localparam int STORE_DEPTH       = 7;

    localparam logic [7:0] START_BYTE = 8'h3C;   // '<'
    localparam logic [7:0] END_BYTE   = 8'h3E;   // '>'

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BADEND = 2'd1;
    localparam logic [1:0] ST_SIZE   = 2'd2;

    typedef logic [7:0] byte_t;

    typedef struct packed {
        logic [1:0]  frame_status;
        logic [7:0]  command_code;
        logic [2:0]  payload_length;
        byte_t [STORE_DEPTH-1:0] data;
        logic [15:0] bad_frame_total;
    } result_t;

endpackage

FILE: sv/fcr_parser.sv
// Frame parsing state machine: one received byte per enabled cycle.
`timescale 1ns / 1ps

module fcr_parser (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step_en,
    input  fcr_pkg::byte_t  rx_byte,
    output logic            emit,
    output fcr_pkg::result_t result
);
    import fcr_pkg::*;

    localparam logic [2:0] PH_WAIT = 3'd0;
    localparam logic [2:0] PH_LEN  = 3'd1;
    localparam logic [2:0] PH_CMD  = 3'd2;
    localparam logic [2:0] PH_DATA = 3'd3;
    localparam logic [2:0] PH_END  = 3'd4;

    logic [2:0]  phase_reg, phase_next;
    logic [2:0]  length_reg, length_next;
    logic [2:0]  index_reg, index_next;
    logic [7:0]  command_reg, command_next;
    logic [15:0] bad_count_reg, bad_count_next;
    byte_t       store_reg [STORE_DEPTH];
    logic        store_we;
    logic        too_long;

    assign too_long = (rx_byte >= 8'(MAX_PAYLOAD_LIMIT)) || (rx_byte > 8'(STORE_DEPTH));

    always_comb
    begin
        phase_next     = phase_reg;
        length_next    = length_reg;
        index_next     = index_reg;
        command_next   = command_reg;
        bad_count_next = bad_count_reg;
        store_we       = 1'b0;
        emit           = 1'b0;
        result         = '0;

        case (phase_reg)
            PH_LEN:
            begin
                if (too_long)
                begin
                    phase_next             = PH_WAIT;
                    emit                   = 1'b1;
                    result.frame_status    = ST_SIZE;
                    result.bad_frame_total = bad_count_reg;
                end
                else
                begin
                    length_next = rx_byte[2:0];
                    phase_next  = PH_CMD;
                end
            end
            PH_CMD:
            begin
                command_next = rx_byte;
                phase_next   = (length_reg != 3'd0) ? PH_DATA : PH_END;
            end
            PH_DATA:
            begin
                store_we   = (index_reg < 3'(STORE_DEPTH));
                index_next = index_reg + 3'd1;
                if (index_next == length_reg)
                begin
                    phase_next = PH_END;
                end
            end
            PH_END:
            begin
                phase_next = PH_WAIT;
                emit       = 1'b1;
                if (rx_byte == END_BYTE)
                begin
                    result.frame_status = ST_OK;
                end
                else
                begin
                    result.frame_status = ST_BADEND;
                    if (bad_count_reg != 16'hFFFF)
                    begin
                        bad_count_next = bad_count_reg + 16'd1;
                    end
                end
                result.command_code    = command_reg;
                result.payload_length  = length_reg;
                result.bad_frame_total = bad_count_next;
                for (int k = 0; k < STORE_DEPTH; k++)
                begin
                    result.data[k] = (3'(k) < length_reg) ? store_reg[k] : 8'd0;
                end
            end
            default:
            begin
                // hunting for the start byte; unused codes land here too
                if (rx_byte == START_BYTE)
                begin
                    phase_next = PH_LEN;
                    index_next = 3'd0;
                end
                else
                begin
                    phase_next = PH_WAIT;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_WAIT;
            length_reg    <= 3'd0;
            index_reg     <= 3'd0;
            command_reg   <= 8'd0;
            bad_count_reg <= 16'd0;
        end
        else if (step_en)
        begin
            phase_reg     <= phase_next;
            length_reg    <= length_next;
            index_reg     <= index_next;
            command_reg   <= command_next;
            bad_count_reg <= bad_count_next;
        end
    end

    // payload bytes are only read below the frame length, so no reset needed
    always_ff @(posedge clk)
    begin
        if (step_en && store_we)
        begin
            store_reg[index_reg] <= rx_byte;
        end
    end

endmodule

FILE: sv/framed_command_receiver.sv
// Framed command receiver top level: input register, parser, two-entry result buffer.
// An accepted byte is parsed when the parser steps (held while the skid entry is full);
//   its result is registered into the buffer and offered from the front entry.
// Throughput: one byte per cycle while the skid entry is empty; the parser step is a single registered pass.
// s_axis_tready depends only on registers; the result buffer holds two entries.
// Reset (rst_n low, asynchronous): parser hunts for '<', counter and buffers empty.
`timescale 1ns / 1ps

module framed_command_receiver (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [87:0] m_axis_tdata,   // command_code, payload_length, data_0..data_6,
                                        // bad_frame_total, zero pad
    output logic [1:0]  m_axis_tuser    // frame_status
);
    import fcr_pkg::*;

    logic    in_valid_reg;
    byte_t   in_byte_reg;
    logic    out_valid_reg, skid_valid_reg;
    result_t out_data_reg, skid_data_reg;
    logic    step_en, emit, pop, push;
    result_t result;

    assign step_en       = in_valid_reg && !skid_valid_reg;
    assign s_axis_tready = !in_valid_reg || !skid_valid_reg;
    assign push          = step_en && emit;
    assign pop           = out_valid_reg && m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
        end
    end

    fcr_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (step_en),
        .rx_byte (in_byte_reg),
        .emit    (emit),
        .result  (result)
    );

    // front entry drives the port; skid entry catches a result while the front stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= push;
            end
            else
            begin
                out_valid_reg <= push;
            end
        end
        else if (push)
        begin
            if (out_valid_reg)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                out_data_reg <= skid_data_reg;
                if (push)
                begin
                    skid_data_reg <= result;
                end
            end
            else if (push)
            begin
                out_data_reg <= result;
            end
        end
        else if (push)
        begin
            if (out_valid_reg)
            begin
                skid_data_reg <= result;
            end
            else
            begin
                out_data_reg <= result;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_data_reg.frame_status;
    assign m_axis_tdata  = {5'd0,
                            out_data_reg.bad_frame_total,
                            out_data_reg.data,
                            out_data_reg.payload_length,
                            out_data_reg.command_code};

endmodule
